>>> sv/point_rotation_about_pivot_defines.svh
// ---------------------------------------------------------------------------
// point_rotation_about_pivot_defines.svh
// Assertion macros shared by the point rotation block. They expect signals
// named clk and rst_n in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef POINT_ROTATION_ABOUT_PIVOT_DEFINES_SVH
`define POINT_ROTATION_ABOUT_PIVOT_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define PRAP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define PRAP_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

>>> sv/prap_pkg.sv
// ---------------------------------------------------------------------------
// prap_pkg
// Types, constants and helpers for the point rotation block.
// ---------------------------------------------------------------------------
`default_nettype none

package prap_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS     = 16;
  localparam int ATAN_LEN       = 30;
  // CORDIC angle accumulator, Q30 radians plus headroom
  localparam int ZW             = 33;

  // Angle reduction, 1/64 degree units
  localparam logic signed [17:0] TURN_S      = 18'sd23040;
  localparam logic signed [17:0] TWO_TURNS_S = 18'sd46080;
  localparam logic [14:0]        QUARTER_U   = 15'd5760;
  localparam logic [14:0]        HALF_U      = 15'd11520;
  localparam logic [14:0]        THREE_Q_U   = 15'd17280;

  // z = round(r * pi * 2^30 / 11520), split as r*PI_DIV + (r*PI_REM + 5760) / 11520.
  // The tail divides by 256 (shift) and then by 45 (reciprocal multiply).
  localparam logic [18:0] PI_DIV      = 19'd292817;
  localparam logic [12:0] PI_REM      = 13'd7586;
  localparam logic [12:0] ROUND_HALF  = 13'd5760;
  localparam logic [18:0] RECIP45     = 19'd372828;
  localparam int          RECIP_SHIFT = 24;

  // Exclusive upper bound on the start angle (pi/2 in Q30)
  localparam logic signed [ZW-1:0] QUARTER_Q30 = 33'sd1686629713;

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef enum logic [1:0] {
    REG_PIVOT_X,
    REG_PIVOT_Y,
    REG_ANGLE,
    REG_CLOCKWISE
  } cfg_reg_t;

  // CORDIC gain seed rounded to frac fractional bits
  function automatic logic [31:0] cordic_x0(input int frac);
    logic [63:0] g;
    g = {32'd0, GAIN_Q30};
    if (frac >= 30) begin
      return g[31:0];
    end
    return 32'((g + (64'd1 << (29 - frac))) >> (30 - frac));
  endfunction

endpackage

`default_nettype wire

>>> sv/prap_front.sv
// ---------------------------------------------------------------------------
// prap_front
// Input stages: pivot translation, angle reduction to quadrant and residue,
// and conversion of the residue to a Q30 start angle. Four register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module prap_front #(
  parameter int COORD_BITS = prap_pkg::COORD_BITS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire  signed [COORD_BITS-1:0]            in_point_x,
  input  wire  signed [COORD_BITS-1:0]            in_point_y,
  input  wire  signed [COORD_BITS-1:0]            pivot_x,
  input  wire  signed [COORD_BITS-1:0]            pivot_y,
  input  wire  signed [prap_pkg::ANGLE_BITS-1:0]  angle_units,
  input  wire                                     clockwise,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [prap_pkg::ZW-1:0]          out_z,
  output prap_pkg::quad_t                         out_quad,
  output logic signed [COORD_BITS:0]              out_dx,
  output logic signed [COORD_BITS:0]              out_dy
);

  localparam int DW = COORD_BITS + 1;
  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  logic signed [DW-1:0] dx_r [NS];
  logic signed [DW-1:0] dy_r [NS];
  prap_pkg::quad_t      quad_r [NS];

  logic [12:0]                  res_r;
  logic [30:0]                  t1_r;
  logic [30:0]                  t1b_r;
  logic [25:0]                  tail_r;
  logic [12:0]                  quot_r;
  logic signed [prap_pkg::ZW-1:0] z_r;

  // angle reduction
  logic signed [17:0] a_s;
  logic signed [17:0] a_red;
  logic [14:0]        a_mod;
  prap_pkg::quad_t    quad_nxt;
  logic [14:0]        res_full;
  logic [36:0]        recip_prod;

  always_comb begin
    a_s = $signed({{2{angle_units[prap_pkg::ANGLE_BITS-1]}}, angle_units});
    if (clockwise) begin
      a_s = -a_s;
    end
    if (a_s < -prap_pkg::TURN_S) begin
      a_red = a_s + prap_pkg::TWO_TURNS_S;
    end else if (a_s < 18'sd0) begin
      a_red = a_s + prap_pkg::TURN_S;
    end else if (a_s >= prap_pkg::TURN_S) begin
      a_red = a_s - prap_pkg::TURN_S;
    end else begin
      a_red = a_s;
    end
    a_mod = a_red[14:0];
    if (a_mod >= prap_pkg::THREE_Q_U) begin
      quad_nxt = prap_pkg::QUAD_3;
      res_full = a_mod - prap_pkg::THREE_Q_U;
    end else if (a_mod >= prap_pkg::HALF_U) begin
      quad_nxt = prap_pkg::QUAD_2;
      res_full = a_mod - prap_pkg::HALF_U;
    end else if (a_mod >= prap_pkg::QUARTER_U) begin
      quad_nxt = prap_pkg::QUAD_1;
      res_full = a_mod - prap_pkg::QUARTER_U;
    end else begin
      quad_nxt = prap_pkg::QUAD_0;
      res_full = a_mod;
    end
  end

  assign recip_prod = 37'(tail_r[25:8]) * 37'(prap_pkg::RECIP45);

  // a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NS] = out_ready;
    for (int k = 0; k < NS; k++) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx_r[0]   <= $signed({in_point_x[COORD_BITS-1], in_point_x})
                 - $signed({pivot_x[COORD_BITS-1], pivot_x});
      dy_r[0]   <= $signed({in_point_y[COORD_BITS-1], in_point_y})
                 - $signed({pivot_y[COORD_BITS-1], pivot_y});
      quad_r[0] <= quad_nxt;
      res_r     <= res_full[12:0];
    end
    if (adv[1]) begin
      dx_r[1]   <= dx_r[0];
      dy_r[1]   <= dy_r[0];
      quad_r[1] <= quad_r[0];
      t1_r      <= 31'(res_r) * 31'(prap_pkg::PI_DIV);
      tail_r    <= 26'(res_r) * 26'(prap_pkg::PI_REM) + 26'(prap_pkg::ROUND_HALF);
    end
    if (adv[2]) begin
      dx_r[2]   <= dx_r[1];
      dy_r[2]   <= dy_r[1];
      quad_r[2] <= quad_r[1];
      t1b_r     <= t1_r;
      quot_r    <= recip_prod[prap_pkg::RECIP_SHIFT+12:prap_pkg::RECIP_SHIFT];
    end
    if (adv[3]) begin
      dx_r[3]   <= dx_r[2];
      dy_r[3]   <= dy_r[2];
      quad_r[3] <= quad_r[2];
      z_r       <= $signed({2'b00, t1b_r} + {20'd0, quot_r});
    end
  end

  assign out_z    = z_r;
  assign out_quad = quad_r[NS-1];
  assign out_dx   = dx_r[NS-1];
  assign out_dy   = dy_r[NS-1];

endmodule

`default_nettype wire

>>> sv/prap_cell.sv
// ---------------------------------------------------------------------------
// prap_cell
// One CORDIC rotation step with its own register stage. The point offset
// and quadrant ride along unchanged.
// ---------------------------------------------------------------------------
`default_nettype none

module prap_cell #(
  parameter int IDX = 0,
  parameter int XW  = prap_pkg::FRAC_BITS_DEF + 3,
  parameter int DW  = prap_pkg::COORD_BITS_DEF + 1
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  signed [XW-1:0]            in_x,
  input  wire  signed [XW-1:0]            in_y,
  input  wire  signed [prap_pkg::ZW-1:0]  in_z,
  input  wire  prap_pkg::quad_t           in_quad,
  input  wire  signed [DW-1:0]            in_dx,
  input  wire  signed [DW-1:0]            in_dy,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic signed [XW-1:0]            out_x,
  output logic signed [XW-1:0]            out_y,
  output logic signed [prap_pkg::ZW-1:0]  out_z,
  output prap_pkg::quad_t                 out_quad,
  output logic signed [DW-1:0]            out_dx,
  output logic signed [DW-1:0]            out_dy
);

  localparam logic signed [prap_pkg::ZW-1:0] ATAN_I =
    $signed({1'b0, prap_pkg::ATAN_Q30[IDX]});

  logic                           v_r;
  logic                           adv;
  logic signed [XW-1:0]           x_r, y_r;
  logic signed [prap_pkg::ZW-1:0] z_r;
  prap_pkg::quad_t                quad_r;
  logic signed [DW-1:0]           dx_r, dy_r;

  logic signed [XW-1:0]           xs, ys, x_nxt, y_nxt;
  logic signed [prap_pkg::ZW-1:0] z_nxt;

  // arithmetic shift is a floor shift
  assign xs = in_x >>> IDX;
  assign ys = in_y >>> IDX;

  always_comb begin
    if (!in_z[prap_pkg::ZW-1]) begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - ATAN_I;
    end else begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + ATAN_I;
    end
  end

  assign adv      = !v_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      quad_r <= in_quad;
      dx_r   <= in_dx;
      dy_r   <= in_dy;
    end
  end

  assign out_valid = v_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_quad  = quad_r;
  assign out_dx    = dx_r;
  assign out_dy    = dy_r;

endmodule

`default_nettype wire

>>> sv/prap_back.sv
// ---------------------------------------------------------------------------
// prap_back
// Output stages: clamp and quadrant map of cos/sin, the four products,
// truncating sums, pivot add and saturation. Last stage is the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module prap_back #(
  parameter int COORD_BITS = prap_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = prap_pkg::FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [FRAC_BITS+2:0]  in_x,
  input  wire  signed [FRAC_BITS+2:0]  in_y,
  input  wire  prap_pkg::quad_t        in_quad,
  input  wire  signed [COORD_BITS:0]   in_dx,
  input  wire  signed [COORD_BITS:0]   in_dy,
  input  wire  signed [COORD_BITS-1:0] pivot_x,
  input  wire  signed [COORD_BITS-1:0] pivot_y,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [COORD_BITS-1:0] out_rotated_x,
  output logic signed [COORD_BITS-1:0] out_rotated_y,
  output logic                         out_saturated
);

  localparam int XW = FRAC_BITS + 3;
  localparam int CW = FRAC_BITS + 2;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + CW;
  localparam int TW = COORD_BITS + 3;
  localparam int NS = 4;

  localparam logic signed [XW-1:0] ONE_X   = $signed({{(XW-1){1'b0}}, 1'b1} << FRAC_BITS);
  localparam logic signed [XW-1:0] M_ONE_X = -ONE_X;
  localparam logic [PW:0]          TRUNC_BIAS = {{(PW+1-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
  localparam logic signed [TW:0]   SAT_HI = $signed({{(TW-COORD_BITS+2){1'b0}},
                                                     {(COORD_BITS-1){1'b1}}});
  localparam logic signed [TW:0]   SAT_LO = $signed({{(TW-COORD_BITS+2){1'b1}},
                                                     {(COORD_BITS-1){1'b0}}});

  logic [NS-1:0] v_r;
  logic [NS:0]   adv;

  logic signed [CW-1:0] c_r, s_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [PW-1:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic signed [TW-1:0] tx_r, ty_r;
  logic signed [COORD_BITS-1:0] rx_r, ry_r;
  logic                 sat_r;

  logic signed [XW-1:0] cx, sx;
  logic signed [CW-1:0] cc, ss, c_nxt, s_nxt;
  logic signed [PW:0]   sum_x, sum_y, bx, by;
  logic signed [TW:0]   fx, fy;
  logic                 hit_x, hit_y;
  logic signed [COORD_BITS-1:0] rx_nxt, ry_nxt;

  // clamp to [-1, 1] and map the first-quadrant pair to the real quadrant
  always_comb begin
    if (in_x > ONE_X) begin
      cx = ONE_X;
    end else if (in_x < M_ONE_X) begin
      cx = M_ONE_X;
    end else begin
      cx = in_x;
    end
    if (in_y > ONE_X) begin
      sx = ONE_X;
    end else if (in_y < M_ONE_X) begin
      sx = M_ONE_X;
    end else begin
      sx = in_y;
    end
    cc = cx[CW-1:0];
    ss = sx[CW-1:0];
    case (in_quad)
      prap_pkg::QUAD_0: begin
        c_nxt = cc;
        s_nxt = ss;
      end
      prap_pkg::QUAD_1: begin
        c_nxt = -ss;
        s_nxt = cc;
      end
      prap_pkg::QUAD_2: begin
        c_nxt = -cc;
        s_nxt = -ss;
      end
      default: begin
        c_nxt = ss;
        s_nxt = -cc;
      end
    endcase
  end

  // exact sums, then truncate toward zero
  always_comb begin
    sum_x = $signed({p_xc_r[PW-1], p_xc_r}) - $signed({p_ys_r[PW-1], p_ys_r});
    sum_y = $signed({p_xs_r[PW-1], p_xs_r}) + $signed({p_yc_r[PW-1], p_yc_r});
    bx    = sum_x[PW] ? $signed(sum_x + TRUNC_BIAS) : sum_x;
    by    = sum_y[PW] ? $signed(sum_y + TRUNC_BIAS) : sum_y;
  end

  always_comb begin
    fx = $signed({tx_r[TW-1], tx_r})
       + $signed({{(TW+1-COORD_BITS){pivot_x[COORD_BITS-1]}}, pivot_x});
    fy = $signed({ty_r[TW-1], ty_r})
       + $signed({{(TW+1-COORD_BITS){pivot_y[COORD_BITS-1]}}, pivot_y});
    hit_x = (fx > SAT_HI) || (fx < SAT_LO);
    hit_y = (fy > SAT_HI) || (fy < SAT_LO);
    if (fx > SAT_HI) begin
      rx_nxt = SAT_HI[COORD_BITS-1:0];
    end else if (fx < SAT_LO) begin
      rx_nxt = SAT_LO[COORD_BITS-1:0];
    end else begin
      rx_nxt = fx[COORD_BITS-1:0];
    end
    if (fy > SAT_HI) begin
      ry_nxt = SAT_HI[COORD_BITS-1:0];
    end else if (fy < SAT_LO) begin
      ry_nxt = SAT_LO[COORD_BITS-1:0];
    end else begin
      ry_nxt = fy[COORD_BITS-1:0];
    end
  end

  always_comb begin
    adv[NS] = out_ready;
    for (int k = 0; k < NS; k++) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      c_r  <= c_nxt;
      s_r  <= s_nxt;
      dx_r <= in_dx;
      dy_r <= in_dy;
    end
    if (adv[1]) begin
      p_xc_r <= PW'(dx_r) * PW'(c_r);
      p_ys_r <= PW'(dy_r) * PW'(s_r);
      p_xs_r <= PW'(dx_r) * PW'(s_r);
      p_yc_r <= PW'(dy_r) * PW'(c_r);
    end
    if (adv[2]) begin
      tx_r <= bx[FRAC_BITS+TW-1:FRAC_BITS];
      ty_r <= by[FRAC_BITS+TW-1:FRAC_BITS];
    end
    if (adv[3]) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      sat_r <= hit_x || hit_y;
    end
  end

  assign out_rotated_x = rx_r;
  assign out_rotated_y = ry_r;
  assign out_saturated = sat_r;

endmodule

`default_nettype wire

>>> sv/point_rotation_about_pivot.sv
// ---------------------------------------------------------------------------
// point_rotation_about_pivot
// Rotates each input point about a configured pivot by a configured angle.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one point per transfer; the
//   result channel (out_valid/out_ready) returns the rotated point and a flag
//   that is set when either coordinate was clipped to the signed range.
//   cfg_we/cfg_index/cfg_wdata write pivot_x, pivot_y, angle_units and
//   clockwise; write them only while no point is in flight.
//   Throughput: one point per cycle while out_ready stays high. The CORDIC runs
//   as a row of FRAC_BITS cells, one rotation step each, so every point carries
//   its own sin/cos. Between input transfer and out_valid lie 4 front stages,
//   FRAC_BITS cells and 4 back stages, all of them register stages.
//   Reset (rst_n low, synchronous) empties the pipeline and clears all
//   configuration registers to zero.
//   When the receiver stalls, each stage holds its point; empty stages still
//   fill, and in_ready drops only once every stage is occupied.
// ---------------------------------------------------------------------------
`default_nettype none

`include "point_rotation_about_pivot_defines.svh"

module point_rotation_about_pivot #(
  parameter int COORD_BITS = prap_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = prap_pkg::FRAC_BITS_DEF,
  localparam int CFG_W     = (COORD_BITS > prap_pkg::ANGLE_BITS) ? COORD_BITS
                                                                  : prap_pkg::ANGLE_BITS
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [COORD_BITS-1:0] in_point_x,
  input  wire  signed [COORD_BITS-1:0] in_point_y,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [COORD_BITS-1:0] out_rotated_x,
  output logic signed [COORD_BITS-1:0] out_rotated_y,
  output logic                         out_saturated,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [CFG_W-1:0]             cfg_wdata
);

  localparam int XW = FRAC_BITS + 3;
  localparam int DW = COORD_BITS + 1;
  localparam logic [31:0] X0_RAW = prap_pkg::cordic_x0(FRAC_BITS);
  localparam logic signed [COORD_BITS-1:0] COORD_MAX =
    $signed({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [COORD_BITS-1:0] COORD_MIN =
    $signed({1'b1, {(COORD_BITS-1){1'b0}}});

  // configuration
  logic signed [COORD_BITS-1:0]          pivot_x_r, pivot_y_r;
  logic signed [prap_pkg::ANGLE_BITS-1:0] angle_r;
  logic                                   cw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_x_r <= '0;
      pivot_y_r <= '0;
      angle_r   <= '0;
      cw_r      <= 1'b0;
    end else if (cfg_we) begin
      case (prap_pkg::cfg_reg_t'(cfg_index))
        prap_pkg::REG_PIVOT_X:   pivot_x_r <= cfg_wdata[COORD_BITS-1:0];
        prap_pkg::REG_PIVOT_Y:   pivot_y_r <= cfg_wdata[COORD_BITS-1:0];
        prap_pkg::REG_ANGLE:     angle_r   <= cfg_wdata[prap_pkg::ANGLE_BITS-1:0];
        prap_pkg::REG_CLOCKWISE: cw_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // chain links, index 0 is the front output
  logic                           ch_valid [FRAC_BITS+1];
  logic                           ch_ready [FRAC_BITS+1];
  logic signed [XW-1:0]           ch_x     [FRAC_BITS+1];
  logic signed [XW-1:0]           ch_y     [FRAC_BITS+1];
  logic signed [prap_pkg::ZW-1:0] ch_z     [FRAC_BITS+1];
  prap_pkg::quad_t                ch_quad  [FRAC_BITS+1];
  logic signed [DW-1:0]           ch_dx    [FRAC_BITS+1];
  logic signed [DW-1:0]           ch_dy    [FRAC_BITS+1];

  assign ch_x[0] = XW'(X0_RAW);
  assign ch_y[0] = '0;

  prap_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .pivot_x     (pivot_x_r),
    .pivot_y     (pivot_y_r),
    .angle_units (angle_r),
    .clockwise   (cw_r),
    .out_valid   (ch_valid[0]),
    .out_ready   (ch_ready[0]),
    .out_z       (ch_z[0]),
    .out_quad    (ch_quad[0]),
    .out_dx      (ch_dx[0]),
    .out_dy      (ch_dy[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    prap_cell #(
      .IDX (i),
      .XW  (XW),
      .DW  (DW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[i]),
      .in_ready  (ch_ready[i]),
      .in_x      (ch_x[i]),
      .in_y      (ch_y[i]),
      .in_z      (ch_z[i]),
      .in_quad   (ch_quad[i]),
      .in_dx     (ch_dx[i]),
      .in_dy     (ch_dy[i]),
      .out_valid (ch_valid[i+1]),
      .out_ready (ch_ready[i+1]),
      .out_x     (ch_x[i+1]),
      .out_y     (ch_y[i+1]),
      .out_z     (ch_z[i+1]),
      .out_quad  (ch_quad[i+1]),
      .out_dx    (ch_dx[i+1]),
      .out_dy    (ch_dy[i+1])
    );
  end

  prap_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (ch_valid[FRAC_BITS]),
    .in_ready      (ch_ready[FRAC_BITS]),
    .in_x          (ch_x[FRAC_BITS]),
    .in_y          (ch_y[FRAC_BITS]),
    .in_quad       (ch_quad[FRAC_BITS]),
    .in_dx         (ch_dx[FRAC_BITS]),
    .in_dy         (ch_dy[FRAC_BITS]),
    .pivot_x       (pivot_x_r),
    .pivot_y       (pivot_y_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rotated_x (out_rotated_x),
    .out_rotated_y (out_rotated_y),
    .out_saturated (out_saturated)
  );

  // assertions
  `PRAP_ASSERT_IMPL(a_stall_from_output, !in_ready, out_valid && !out_ready, "input stalled without an output stall")
  `PRAP_ASSERT_IMPL(a_start_angle_range, ch_valid[0], !ch_z[0][prap_pkg::ZW-1] && (ch_z[0] < prap_pkg::QUARTER_Q30), "start angle outside first quadrant")
  `PRAP_ASSERT_IMPL(a_sat_at_bound, out_valid && out_saturated, (out_rotated_x == COORD_MAX) || (out_rotated_x == COORD_MIN) || (out_rotated_y == COORD_MAX) || (out_rotated_y == COORD_MIN), "saturated flag without a clipped coordinate")
  `PRAP_ASSERT_AFTER_RESET(a_reset_empty, !out_valid && in_ready, "pipeline not empty after reset")

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: point rotation about a pivot
// Drives points through the rotation block under several pivot/angle settings
// (directed corners first, then random phases, all but one with random idles and stalls).
// A scoreboard predicts each rotated point with its own CORDIC and checks
// every result transfer in order.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int     FRAC           = 16;
  localparam longint ONE_Q          = 64'sd1 <<< FRAC;
  localparam longint TURN           = 23040;
  localparam longint QUARTER        = 5760;
  localparam longint HALF_TURN      = 11520;
  localparam longint PI_Q30         = 64'sd3373259426;
  localparam longint COORD_MAX      = 32767;
  localparam longint COORD_MIN      = -32768;
  localparam int     WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               sat;
  } rotated_point_t;

  class rotation_scoreboard;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic signed [15:0] angle;
    logic               cw;
    rotated_point_t     expected_q[$];
    int                 errors;

    function new();
      pivot_x = '0;
      pivot_y = '0;
      angle   = '0;
      cw      = 1'b0;
      errors  = 0;
    endfunction

    function longint trunc_frac(longint v);
      return (v >= 0) ? (v >>> FRAC) : -((-v) >>> FRAC);
    endfunction

    // Rotate one accepted point with the current setting and queue the result
    function void note_input(logic signed [15:0] px, logic signed [15:0] py);
      longint a, q, r, x, y, z, xs, ys, c, s, dx, dy, xn, yn;
      rotated_point_t want;
      a = angle;
      if (cw) a = -a;
      a = a % TURN;
      if (a < 0) a += TURN;
      q = a / QUARTER;
      r = a - q * QUARTER;
      // CORDIC seed: gain rounded from Q30 to FRAC bits
      x = (longint'(prap_pkg::GAIN_Q30) + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      y = 0;
      z = (r * PI_Q30 + QUARTER) / HALF_TURN;
      for (int i = 0; i < FRAC; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(prap_pkg::ATAN_Q30[i]);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(prap_pkg::ATAN_Q30[i]);
        end
      end
      if (x > ONE_Q) x = ONE_Q;
      if (x < -ONE_Q) x = -ONE_Q;
      if (y > ONE_Q) y = ONE_Q;
      if (y < -ONE_Q) y = -ONE_Q;
      case (prap_pkg::quad_t'(q[1:0]))
        prap_pkg::QUAD_0: begin
          c = x;
          s = y;
        end
        prap_pkg::QUAD_1: begin
          c = -y;
          s = x;
        end
        prap_pkg::QUAD_2: begin
          c = -x;
          s = -y;
        end
        default: begin
          c = y;
          s = -x;
        end
      endcase
      dx = longint'(px) - longint'(pivot_x);
      dy = longint'(py) - longint'(pivot_y);
      xn = trunc_frac(dx * c - dy * s) + longint'(pivot_x);
      yn = trunc_frac(dx * s + dy * c) + longint'(pivot_y);
      want.sat = 1'b0;
      if (xn > COORD_MAX) begin
        xn = COORD_MAX;
        want.sat = 1'b1;
      end else if (xn < COORD_MIN) begin
        xn = COORD_MIN;
        want.sat = 1'b1;
      end
      if (yn > COORD_MAX) begin
        yn = COORD_MAX;
        want.sat = 1'b1;
      end else if (yn < COORD_MIN) begin
        yn = COORD_MIN;
        want.sat = 1'b1;
      end
      want.x = xn[15:0];
      want.y = yn[15:0];
      expected_q.push_back(want);
    endfunction

    function void check_result(logic signed [15:0] x, logic signed [15:0] y, logic sat);
      rotated_point_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual x=%0d y=%0d sat=%0b",
                 $time, x, y, sat);
        return;
      end
      want = expected_q.pop_front();
      if (x !== want.x) begin
        errors++;
        $display("%0t: rotated_x expected %0d actual %0d", $time, want.x, x);
      end
      if (y !== want.y) begin
        errors++;
        $display("%0t: rotated_y expected %0d actual %0d", $time, want.y, y);
      end
      if (sat !== want.sat) begin
        errors++;
        $display("%0t: saturated expected %0b actual %0b", $time, want.sat, sat);
      end
    endfunction
  endclass

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_point_x    = '0;
  logic signed [15:0] in_point_y    = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic signed [15:0] out_rotated_x;
  logic signed [15:0] out_rotated_y;
  logic               out_saturated;
  logic               cfg_we        = 1'b0;
  prap_pkg::cfg_reg_t cfg_index     = prap_pkg::REG_PIVOT_X;
  logic [15:0]        cfg_wdata     = '0;

  rotation_scoreboard sb = new();

  bit gaps_on      = 1'b1;
  bit stalls_on    = 1'b1;
  int sent_count   = 0;
  int done_count   = 0;
  int quiet_cycles = 0;

  point_rotation_about_pivot dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y),
    .out_saturated(out_saturated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= stalls_on ? ($urandom_range(99) >= 15) : 1'b1;
  end

  // Transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_point_x, in_point_y);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_rotated_x, out_rotated_y, out_saturated);
        done_count++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog expired, %0d results outstanding", $time,
                   sent_count - done_count);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // Hold off the sender until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (done_count != sent_count) @(posedge clk);
  endtask

  task automatic set_rotation(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic signed [15:0] ang, input logic [15:0] cw_word);
    logic [15:0] vals [4];
    vals = '{px, py, ang, cw_word};
    drain();
    cfg_we <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= prap_pkg::cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    sb.pivot_x = px;
    sb.pivot_y = py;
    sb.angle   = ang;
    sb.cw      = cw_word[0];
  endtask

  task automatic send_corners();
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh0000, 16'sh7fff);
  endtask

  // Mostly full-range values, some close to the pivot, some at the edges
  function automatic logic signed [15:0] rand_coord(logic signed [15:0] center);
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 16'($urandom);
    if (pick < 85) return center + 16'(int'($urandom_range(4000)) - 2000);
    case ($urandom_range(3))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'(int'($urandom_range(46080)) - 23040);
      1: return 16'($urandom);
      2: return 16'(int'($urandom_range(8)) * 5760 - 23040 + int'($urandom_range(4)) - 2);
      default: return 16'(int'($urandom_range(128)) - 64);
    endcase
  endfunction

  initial begin
    logic signed [15:0] px, py;
    int                 n_items;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: quarter turns, full turns both ways, 16-bit angle ends,
    // pivots at the corners, clockwise with junk in the upper data bits
    set_rotation(16'sd0, 16'sd0, 16'sd0, 16'h0000);
    send_corners();
    set_rotation(16'sd100, -16'sd200, 16'sd5760, 16'h0000);
    send_corners();
    set_rotation(16'sh8000, 16'sh7fff, 16'sd11520, 16'h0001);
    send_corners();
    set_rotation(16'sh7fff, 16'sh8000, 16'sd17280, 16'h0000);
    send_corners();
    set_rotation(16'sd0, 16'sd0, 16'sd23040, 16'h0001);
    send_corners();
    set_rotation(16'sd1234, -16'sd4321, -16'sd23040, 16'hfffe);
    send_corners();
    set_rotation(-16'sd1, 16'sd1, 16'sh7fff, 16'hffff);
    send_corners();
    set_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'h0000);
    send_corners();

    for (int phase = 0; phase < 12; phase++) begin
      set_rotation(rand_coord(16'sd0), rand_coord(16'sd0), rand_angle(), 16'($urandom));
      gaps_on   = (phase != 5);
      stalls_on = (phase != 5);
      n_items   = (phase == 5) ? 300 : 136;
      for (int k = 0; k < n_items; k++) begin
        if (phase == 3 && k == 70) drain();
        px = rand_coord(sb.pivot_x);
        py = rand_coord(sb.pivot_y);
        send_point(px, py);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+sv
sv/prap_pkg.sv
sv/prap_front.sv
sv/prap_cell.sv
sv/prap_back.sv
sv/point_rotation_about_pivot.sv
verif/tb_top.sv
